@@ rtl/cfd_pkg.sv @@
// Shared types and constants of the CPPM frame decoder.
package cfd_pkg;

   // Transaction kinds on the request channel
   typedef enum logic [1:0] {
      ACT_EDGE        = 2'd0,
      ACT_READ_SLOT   = 2'd1,
      ACT_READ_BUCKET = 2'd2,
      ACT_NONE        = 2'd3
   } cfd_action_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_PULSE_MIN = 2'd0,
      CSR_PULSE_MAX = 2'd1,
      CSR_SYNC_MIN  = 2'd2,
      CSR_DEFAULT   = 2'd3
   } cfd_csr_type;

   // Register reset values in microseconds
   localparam logic [15:0] PULSE_MIN_RST = 16'd900;
   localparam logic [15:0] PULSE_MAX_RST = 16'd2100;
   localparam logic [15:0] SYNC_MIN_RST  = 16'd3000;
   localparam logic [15:0] DEFAULT_RST   = 16'd1500;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;
      logic eval;
      logic div_step;
      logic incr;
      logic out_load;
   } cfd_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic pulse_ok;
      logic div_last;
      logic out_free;
   } cfd_status_type;

endpackage

@@ rtl/cppm_frame_decoder_unit.sv @@
// Top level of the CPPM frame decoder: controller joined to datapath.
// Path: a request is loaded in IDLE, evaluated in EVAL and passed to the output register from OUT;
// an edge that stores a pulse also goes through DIV, one step per quotient bit, and INCR before OUT.
// Flow: one transaction at a time, the next accepted only once the controller is back in IDLE;
// the bucket divider, one quotient bit a cycle, makes a stored pulse take longer than a short one.
// Reset: synchronous, clears pointer, last edge time and counters, loads slots with 1500 us.
module cppm_frame_decoder_unit
   import cfd_pkg::*;
#(
   parameter int CHANNELS = 8,
   parameter int BUCKETS  = 10
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_edge_time_us,
   input  logic [3:0]  req_item_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic [3:0]  rsp_frame_position,
   output logic        rsp_sync_seen,
   output logic        rsp_pulse_stored,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfd_cmd_type    cmd;
   cfd_status_type status;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   cfd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cfd_datapath #(
      .CHANNELS (CHANNELS),
      .BUCKETS  (BUCKETS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_action         (req_action),
      .req_edge_time_us   (req_edge_time_us),
      .req_item_index     (req_item_index),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_data      (rsp_read_data),
      .rsp_frame_position (rsp_frame_position),
      .rsp_sync_seen      (rsp_sync_seen),
      .rsp_pulse_stored   (rsp_pulse_stored)
   );

endmodule

@@ rtl/cfd_controller.sv @@
// Sequencing state machine of the CPPM frame decoder.
module cfd_controller
   import cfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  cfd_status_type status,
   output cfd_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EVAL = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_INCR = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Take a new transaction only when idle
   assign req_stall = (state_ff != ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.pulse_ok ? ST_DIV : ST_OUT;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_INCR;
         end
         ST_INCR: begin
            cmd.incr = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/cfd_datapath.sv @@
// Datapath of the CPPM frame decoder: registers, slots, histogram and divider.
module cfd_datapath
   import cfd_pkg::*;
#(
   parameter int CHANNELS = 8,
   parameter int BUCKETS  = 10
)
(
   input  logic           clock,
   input  logic           reset,
   input  cfd_cmd_type    cmd,
   output cfd_status_type status,
   input  logic [1:0]     req_action,
   input  logic [31:0]    req_edge_time_us,
   input  logic [3:0]     req_item_index,
   input  logic           csr_write,
   input  logic [1:0]     csr_index,
   input  logic [15:0]    csr_wdata,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [31:0]    rsp_read_data,
   output logic [3:0]     rsp_frame_position,
   output logic           rsp_sync_seen,
   output logic           rsp_pulse_stored
);

   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PW = $clog2(CHANNELS + 1);
   localparam int QW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int DW = 16 + $clog2(BUCKETS + 1);
   localparam int WW = 17 + QW;
   localparam int SW = (QW > 1) ? $clog2(QW) : 1;

   // Configuration
   logic [15:0] pulse_min_ff, pulse_max_ff, sync_min_ff;

   // Captured transaction
   cfd_action_type action_ff;
   logic [3:0]     idx_ff;
   logic [31:0]    gap_ff;
   logic [31:0]    prev_ff;

   // Frame state
   logic [PW-1:0]  ptr_ff;
   logic [15:0]    slots_ff [CHANNELS];
   logic [31:0]    bucket_ff [BUCKETS];

   // Divider
   logic [WW-1:0]  rem_ff, dsh_ff;
   logic [QW-1:0]  quo_ff;
   logic [SW-1:0]  step_ff;

   // Result held until output register frees
   logic [31:0]    data_ff;
   logic           sync_ff, stored_ff;

   // Output register
   logic           rsp_valid_ff;
   logic [31:0]    rsp_data_ff;
   logic [3:0]     rsp_pos_ff;
   logic           rsp_sync_ff, rsp_stored_ff;

   logic           is_edge, is_sync, in_window, has_room, pulse_ok, trial;
   logic [15:0]    rel;
   logic [DW-1:0]  prod;
   logic [16:0]    span1;
   logic [QW-1:0]  qsel, baddr;
   logic [31:0]    bucket_rd, read_val;

   // Classify the gap and pick the bucket read address
   always_comb begin
      is_edge   = (action_ff == ACT_EDGE);
      is_sync   = gap_ff > {16'd0, sync_min_ff};
      in_window = (gap_ff >= {16'd0, pulse_min_ff}) && (gap_ff <= {16'd0, pulse_max_ff});
      has_room  = ptr_ff < PW'(CHANNELS);
      pulse_ok  = is_edge && !is_sync && in_window && has_room;
      rel       = gap_ff[15:0] - pulse_min_ff;
      prod      = DW'(rel) * DW'(BUCKETS);
      span1     = {1'b0, pulse_max_ff} - {1'b0, pulse_min_ff} + 17'd1;
      trial     = rem_ff >= dsh_ff;
      qsel      = ({1'b0, quo_ff} >= (QW + 1)'(BUCKETS)) ? QW'(BUCKETS - 1) : quo_ff;
      baddr     = cmd.incr ? qsel : idx_ff[QW-1:0];
      bucket_rd = bucket_ff[baddr];
      case (action_ff)
         ACT_READ_SLOT:
            read_val = ({1'b0, idx_ff} < 5'(CHANNELS)) ? {16'd0, slots_ff[idx_ff[CW-1:0]]} : '0;
         ACT_READ_BUCKET:
            read_val = ({1'b0, idx_ff} < 5'(BUCKETS)) ? bucket_rd : '0;
         default:
            read_val = '0;
      endcase
   end

   assign status.pulse_ok = pulse_ok;
   assign status.div_last = (step_ff == '0);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // Configuration registers; a write to CSR_DEFAULT is ignored, the slots always reset to DEFAULT_RST
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_min_ff <= PULSE_MIN_RST;
         pulse_max_ff <= PULSE_MAX_RST;
         sync_min_ff  <= SYNC_MIN_RST;
      end else if (csr_write) begin
         unique case (cfd_csr_type'(csr_index))
            CSR_PULSE_MIN: pulse_min_ff <= csr_wdata;
            CSR_PULSE_MAX: pulse_max_ff <= csr_wdata;
            CSR_SYNC_MIN:  sync_min_ff  <= csr_wdata;
            CSR_DEFAULT:   ;
         endcase
      end
   end

   // Capture the transaction and the edge gap
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (cmd.load && (req_action == ACT_EDGE)) begin
         prev_ff <= req_edge_time_us;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= cfd_action_type'(req_action);
         idx_ff    <= req_item_index;
         gap_ff    <= req_edge_time_us - prev_ff;
      end
   end

   // Frame pointer and channel slots
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) slots_ff[i] <= DEFAULT_RST;
      end else if (cmd.eval) begin
         if (is_edge && is_sync) begin
            ptr_ff <= '0;
         end else if (pulse_ok) begin
            slots_ff[ptr_ff[CW-1:0]] <= gap_ff[15:0];
            ptr_ff                   <= ptr_ff + PW'(1);
         end
      end
   end

   // Histogram counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUCKETS; i++) bucket_ff[i] <= '0;
      end else if (cmd.incr) begin
         bucket_ff[qsel] <= bucket_rd + 32'd1;
      end
   end

   // Restoring divider, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         rem_ff  <= WW'(prod);
         dsh_ff  <= WW'(span1) << (QW - 1);
         quo_ff  <= '0;
         step_ff <= SW'(QW - 1);
      end else if (cmd.div_step) begin
         if (trial) rem_ff <= rem_ff - dsh_ff;
         dsh_ff  <= dsh_ff >> 1;
         quo_ff  <= QW'({quo_ff, trial});
         step_ff <= step_ff - SW'(1);
      end
   end

   // Hold the result of this transaction
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         data_ff   <= read_val;
         sync_ff   <= is_edge && is_sync;
         stored_ff <= pulse_ok;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff   <= data_ff;
         rsp_pos_ff    <= 4'(ptr_ff);
         rsp_sync_ff   <= sync_ff;
         rsp_stored_ff <= stored_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rsp_data_ff;
   assign rsp_frame_position = rsp_pos_ff;
   assign rsp_sync_seen      = rsp_sync_ff;
   assign rsp_pulse_stored   = rsp_stored_ff;

endmodule

@@ rtl/cfd_checker.sv @@
// Port-level assertions for the CPPM frame decoder and their binding.
module cfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_read_data,
   input logic [3:0]  rsp_frame_position,
   input logic        rsp_sync_seen,
   input logic        rsp_pulse_stored
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_frame_position))
      else $error("stalled response changed");

   // Work on one transaction at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // Sync and store exclude each other
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_sync_seen && rsp_pulse_stored))
      else $error("sync and store both flagged");

   // Sync restarts the frame
   a_sync_restarts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sync_seen |-> rsp_frame_position == 4'd0)
      else $error("sync with non-zero frame position");

endmodule

bind cppm_frame_decoder_unit cfd_checker u_cfd_checker (.*);
